// ----- hdl/oaht_pkg.sv -----
package oaht_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int KEY_BYTES   = 8;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int KEY_W       = 8 * KEY_BYTES;
    localparam int LEN_W       = 4;
    localparam int VAL_W       = 64;
    localparam logic [CNT_W-1:0] LOAD_LIMIT = CNT_W'((TABLE_SLOTS * 3) / 4);
    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    // occupied flag, tombstone flag, key, length, value
    localparam int ENTRY_W = 2 + KEY_W + LEN_W + VAL_W;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_DEL   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_RD,
        S_WAIT,
        S_CHECK,
        S_DECIDE,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic rd;
        logic probe_next;
        logic tomb_mark;
        logic pick_tomb;
        logic do_write;
        logic do_delete;
        logic do_clear;
        logic result;
        status_t status;
        logic is_new;
        logic inc_used;
    } ctrl_t;

    typedef struct packed {
        logic hash_done;
        logic slot_occ;
        logic slot_tomb;
        logic key_match;
        logic have_tomb;
        logic last_probe;
        logic at_limit;
    } stat_t;

endpackage

// ----- hdl/oaht_ram.sv -----
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/oaht_datapath.sv -----
module oaht_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  oaht_pkg::ctrl_t           ctrl,
    output oaht_pkg::stat_t           stat,
    input  logic [1:0]                in_cmd,
    input  logic [63:0]               in_key,
    input  logic [3:0]                in_len,
    input  logic [63:0]               in_value,
    output logic [1:0]                cmd,
    output logic [1:0]                res_status,
    output logic                      res_is_new,
    output logic [63:0]               res_value
);
    import oaht_pkg::*;

    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [1:0]        cmd_reg;
    logic [31:0]       hash_reg, hash_next;
    logic [LEN_W-1:0]  hcnt_reg;
    logic [SLOT_W-1:0] idx_reg, tomb_reg, pos_reg;
    logic [CNT_W-1:0]  nprobe_reg;
    logic              have_tomb_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [TABLE_SLOTS-1:0] live_reg;
    logic              live_q;
    logic [1:0]        wflags;
    logic [ENTRY_W-1:0] rdata;
    logic [SLOT_W-1:0] raddr;
    logic [LEN_W-1:0]  len_clip;
    logic [KEY_W-1:0]  key_mask;
    logic [7:0]        hbyte;

    always_comb begin
        len_clip = (in_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_len;
        for (int i = 0; i < KEY_BYTES; i++) begin
            key_mask[8*i +: 8] = (LEN_W'(i) < len_clip) ? 8'hFF : 8'h00;
        end
        hbyte = key_reg[8*hcnt_reg[$clog2(KEY_BYTES+1)-1:0] +: 8];
        hash_next = (hash_reg ^ {24'd0, hbyte}) * FNV_PRIME;
    end

    assign raddr = idx_reg;
    // occupied on insert, tombstone on delete
    assign wflags = ctrl.do_write ? 2'b10 : 2'b01;

    oaht_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (ctrl.do_write || ctrl.do_delete),
        .waddr (pos_reg),
        .wdata ({wflags, key_reg, len_reg, val_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            key_reg  <= in_key[KEY_W-1:0] & key_mask;
            len_reg  <= len_clip;
            val_reg  <= in_value;
            cmd_reg  <= in_cmd;
            hash_reg <= FNV_OFFSET;
            hcnt_reg <= '0;
            have_tomb_reg <= 1'b0;
            nprobe_reg <= '0;
        end
        if (ctrl.hash_step) begin
            hash_reg <= hash_next;
            hcnt_reg <= hcnt_reg + 1'b1;
        end
        if (stat.hash_done && !ctrl.probe_next && !ctrl.hash_step && !ctrl.rd
            && !ctrl.load && nprobe_reg == '0 && !have_tomb_reg) begin
            idx_reg <= hash_reg[SLOT_W-1:0];
        end
        if (ctrl.tomb_mark) begin
            have_tomb_reg <= 1'b1;
            tomb_reg <= idx_reg;
        end
        if (ctrl.probe_next) begin
            idx_reg <= idx_reg + 1'b1;
            nprobe_reg <= nprobe_reg + 1'b1;
        end
        if (ctrl.rd) begin
            pos_reg <= idx_reg;
        end
        if (ctrl.pick_tomb) begin
            pos_reg <= tomb_reg;
        end
        if (ctrl.result) begin
            res_status <= ctrl.status;
            res_is_new <= ctrl.is_new;
            res_value  <= (ctrl.status == ST_DONE && cmd_reg == CMD_GET && !ctrl.do_clear)
                          ? rdata[VAL_W-1:0] : '0;
        end
    end

    // one written-since-clear bit per slot qualifies the flags in the RAM
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.do_clear) begin
            live_reg <= '0;
            used_reg <= '0;
        end else begin
            if (ctrl.do_write || ctrl.do_delete) begin
                live_reg[pos_reg] <= 1'b1;
            end
            if (ctrl.inc_used) begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        live_q <= live_reg[raddr];
    end

    assign cmd = cmd_reg;
    assign stat.hash_done  = (hcnt_reg >= len_reg);
    assign stat.slot_occ   = live_q && rdata[ENTRY_W-1];
    assign stat.slot_tomb  = live_q && rdata[ENTRY_W-2];
    assign stat.key_match  = (rdata[VAL_W+LEN_W +: KEY_W] == key_reg)
                             && (rdata[VAL_W +: LEN_W] == len_reg);
    assign stat.have_tomb  = have_tomb_reg;
    assign stat.last_probe = (nprobe_reg == CNT_W'(TABLE_SLOTS - 1));
    assign stat.at_limit   = (used_reg + 1'b1 > LOAD_LIMIT);
endmodule

// ----- hdl/oaht_ctrl.sv -----
module oaht_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [1:0]       in_cmd,
    input  logic [1:0]       cmd,
    input  logic             out_free,
    input  oaht_pkg::stat_t  stat,
    output oaht_pkg::ctrl_t  ctrl,
    output logic             busy
);
    import oaht_pkg::*;

    state_t state_reg, state_next;
    logic   found_reg, found_next;
    logic   empty_reg, empty_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            empty_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            found_reg <= found_next;
            empty_reg <= empty_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        found_next = found_reg;
        empty_next = empty_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = (in_cmd == CMD_CLEAR) ? S_OUT : S_HASH;
                end
            end
            S_HASH:  if (stat.hash_done) state_next = S_RD;
            S_RD:    state_next = S_WAIT;
            S_WAIT:  state_next = S_CHECK;
            S_CHECK: begin
                if (stat.slot_occ && stat.key_match) begin
                    found_next = 1'b1;
                    empty_next = 1'b0;
                    state_next = S_DECIDE;
                end else if (!stat.slot_occ && !stat.slot_tomb) begin
                    found_next = 1'b0;
                    empty_next = 1'b1;
                    state_next = S_DECIDE;
                end else if (stat.last_probe) begin
                    found_next = 1'b0;
                    empty_next = 1'b0;
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_RD;
                end
            end
            S_DECIDE: state_next = S_WRITE;
            S_WRITE:  state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.status = ST_DONE;
        case (state_reg)
            S_IDLE:  ctrl.load = in_fire;
            S_HASH:  ctrl.hash_step = !stat.hash_done;
            S_RD:    ctrl.rd = 1'b1;
            S_CHECK: begin
                if (!stat.slot_occ && stat.slot_tomb && !stat.have_tomb) begin
                    ctrl.tomb_mark = 1'b1;
                end
                if (!(stat.slot_occ && stat.key_match)
                    && (stat.slot_occ || stat.slot_tomb)) begin
                    ctrl.probe_next = 1'b1;
                end
            end
            S_DECIDE: ctrl.pick_tomb = !found_reg && stat.have_tomb;
            S_WRITE: begin
                ctrl.result = 1'b1;
                case (cmd)
                    CMD_SET: begin
                        if (found_reg) begin
                            ctrl.do_write = 1'b1;
                        end else if (stat.have_tomb) begin
                            ctrl.do_write = 1'b1;
                            ctrl.is_new = 1'b1;
                        end else if (!empty_reg || stat.at_limit) begin
                            ctrl.status = ST_FULL;
                        end else begin
                            ctrl.do_write = 1'b1;
                            ctrl.is_new = 1'b1;
                            ctrl.inc_used = 1'b1;
                        end
                    end
                    CMD_GET: ctrl.status = found_reg ? ST_DONE : ST_NOTFOUND;
                    default: begin
                        ctrl.status = found_reg ? ST_DONE : ST_NOTFOUND;
                        ctrl.do_delete = found_reg;
                    end
                endcase
            end
            S_OUT: begin
                if (cmd == CMD_CLEAR && !out_free) begin
                    ctrl.result = 1'b0;
                end
            end
            default: ;
        endcase
        if (state_reg == S_IDLE && in_fire && in_cmd == CMD_CLEAR) begin
            ctrl.do_clear = 1'b1;
            ctrl.result = 1'b1;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_out_only_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.do_write |-> state_reg == S_WRITE) else $error("write outside write state");
    a_no_wr_del: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.do_write && ctrl.do_delete)) else $error("write and delete together");
    a_inc_new: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.inc_used |-> ctrl.is_new) else $error("count grew without new entry");
endmodule

// ----- hdl/open_addressing_hash_table_unit.sv -----
// Result: clear raises m_tvalid right after its accepting edge; other commands raise it
// after hashing each key byte, a read, wait and check per probed slot, then decide and write.
// Flow: one command at a time; the next word is taken once the unit is back in idle and
// m_tvalid has dropped with m_tready high.
// Reset: synchronous active-low aresetn empties all slots (one written bit per slot
// in flops; occupied/tombstone flags sit in the slot RAM) and zeroes the used count.
module open_addressing_hash_table_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // cmd[1:0], key_bytes[65:2], key_len[69:66], value_in[133:70]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata   // status[1:0], is_new[2], value_out[66:3]
);
    import oaht_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic  busy, in_fire, out_free;
    logic  mvalid_reg;
    logic [1:0]  cmd, res_status;
    logic        res_is_new;
    logic [63:0] res_value;

    assign s_tready = !busy && !mvalid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    oaht_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_cmd(s_tdata[1:0]),
        .cmd(cmd), .out_free(1'b1), .stat(stat), .ctrl(ctrl), .busy(busy)
    );

    oaht_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .in_cmd(s_tdata[1:0]), .in_key(s_tdata[65:2]), .in_len(s_tdata[69:66]),
        .in_value(s_tdata[133:70]), .cmd(cmd), .res_status(res_status),
        .res_is_new(res_is_new), .res_value(res_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (ctrl.result) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {5'd0, res_value, res_is_new, res_status};

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready) else $error("accepted while busy");
    a_result_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.result |-> out_free) else $error("result overwrote pending word");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("bad status");
endmodule
